// File: hdl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// checked only out of reset
`define ISS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("iss assertion failed");
// checked at every edge, reset included
`define ISS_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("iss assertion failed");
`else
`define ISS_ASSERT(lbl, clk, rst_n, prop)
`define ISS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: hdl/iss_pkg.sv
`timescale 1ns / 1ps
package iss_pkg;

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned POS_W   = 7;
	localparam int unsigned CNT_O_W = 7;
	// wide enough for any position, count or index up to the largest capacity
	localparam int unsigned IDX_W   = 11;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_READ   = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]              cmd;
		logic [POS_W-1:0]        position;
		logic                    from_end;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		logic [1:0]              status;
		logic [CNT_O_W-1:0]      entry_count;
	} rsp_t;

	// control broadcast to every cell of the row
	typedef struct packed {
		logic             ins;
		logic             rem;
		logic             rd;
		logic [IDX_W-1:0] idx;
	} cell_ctl_t;

endpackage

// File: hdl/iss_word_if.sv
`timescale 1ns / 1ps
interface iss_word_if #(parameter type word_t = logic);
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/iss_cell.sv
`timescale 1ns / 1ps
module iss_cell #(
	parameter int unsigned INDEX = 0
) (
	input  logic                             clk,
	input  iss_pkg::cell_ctl_t               ctl,
	input  logic signed [iss_pkg::DATA_W-1:0] value,
	input  logic signed [iss_pkg::DATA_W-1:0] left,
	input  logic signed [iss_pkg::DATA_W-1:0] right,
	output logic signed [iss_pkg::DATA_W-1:0] entry,
	output logic signed [iss_pkg::DATA_W-1:0] tap
);

	localparam logic [iss_pkg::IDX_W-1:0] MY_IDX = iss_pkg::IDX_W'(INDEX);

	logic signed [iss_pkg::DATA_W-1:0] entry_q;
	logic                              hit;
	logic                              above;

	assign hit   = (ctl.idx == MY_IDX);
	assign above = (MY_IDX > ctl.idx);

	// shift toward the tail on insert, toward the head on remove
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (hit) begin
				entry_q <= value;
			end else if (above) begin
				entry_q <= left;
			end
		end else if (ctl.rem) begin
			if (hit || above) begin
				entry_q <= right;
			end
		end
	end

	assign entry = entry_q;

	// read tap, zero unless this cell is addressed by a read
	assign tap = (ctl.rd && hit) ? entry_q : '0;

endmodule

// File: hdl/iss_or_tree.sv
`timescale 1ns / 1ps
module iss_or_tree #(
	parameter int unsigned N = 64
) (
	input  logic signed [iss_pkg::DATA_W-1:0] leaf [N],
	output logic signed [iss_pkg::DATA_W-1:0] root
);

	localparam int unsigned P = (N <= 1) ? 2 : (1 << $clog2(N));

	logic signed [iss_pkg::DATA_W-1:0] node [2*P-1];

	// leaves, padded with zero up to a power of two
	for (genvar i = 0; i < P; i++) begin : g_leaf
		if (i < N) begin : g_used
			assign node[P-1+i] = leaf[i];
		end else begin : g_pad
			assign node[P-1+i] = '0;
		end
	end

	// inner nodes
	for (genvar j = 0; j < P-1; j++) begin : g_node
		assign node[j] = node[2*j+1] | node[2*j+2];
	end

	assign root = node[0];

endmodule

// File: hdl/indexed_sequence_store.sv
`timescale 1ns / 1ps
// Ordered store of up to CAPACITY signed 32-bit entries, kept in a row of cells
// that shift together. Each request word inserts, removes or reads at a
// position (optionally counted from the end); each yields one response word
// with the read value, a status and the entry count. The whole row shifts in
// the cycle the word is accepted and the response is registered, showing on
// rsp in the next cycle. A new request is taken in every cycle in which the
// response register is empty or being drained, so the throughput is one word
// per cycle. The read path is a CAPACITY-wide OR tree over the cell taps. No
// clearing pass after reset.
module indexed_sequence_store #(
	parameter int unsigned CAPACITY = 64
) (
	input logic             clk,
	input logic             arst_n,
	iss_word_if.sink        req,
	iss_word_if.source      rsp
);

	`include "assert_macros.svh"

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam logic [iss_pkg::IDX_W-1:0] CAP_X = iss_pkg::IDX_W'(CAPACITY);

	logic [CNT_W-1:0]          count_q;
	logic                      out_valid_q;
	iss_pkg::rsp_t             out_q;

	logic                      accept;
	logic [iss_pkg::IDX_W-1:0] cnt_x;
	logic [iss_pkg::IDX_W-1:0] pos_x;
	logic                      is_ins;
	logic                      is_rem;
	logic                      is_rd;
	logic                      ins_range_bad;
	logic                      acc_range_bad;
	logic                      full;
	logic [CNT_W-1:0]          count_d;
	iss_pkg::status_t          status_d;
	iss_pkg::cell_ctl_t        ctl;

	logic signed [iss_pkg::DATA_W-1:0] entry [CAPACITY];
	logic signed [iss_pkg::DATA_W-1:0] tap [CAPACITY];
	logic signed [iss_pkg::DATA_W-1:0] rd_data;

	// handshake
	assign req.ready = !out_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	// decode and range checks
	assign cnt_x = iss_pkg::IDX_W'(count_q);
	assign pos_x = iss_pkg::IDX_W'(req.data.position);
	assign is_ins = (req.data.cmd == iss_pkg::CMD_INSERT);
	assign is_rem = (req.data.cmd == iss_pkg::CMD_REMOVE);
	assign is_rd  = (req.data.cmd == iss_pkg::CMD_READ);
	assign ins_range_bad = (pos_x > cnt_x);
	assign acc_range_bad = (pos_x >= cnt_x);
	assign full          = (cnt_x == CAP_X);

	// cell control
	always_comb begin
		ctl.ins = accept && is_ins && !ins_range_bad && !full;
		ctl.rem = accept && is_rem && !acc_range_bad;
		ctl.rd  = is_rd && !acc_range_bad;
		if (is_ins) begin
			ctl.idx = req.data.from_end ? (cnt_x - pos_x) : pos_x;
		end else begin
			ctl.idx = req.data.from_end ? (cnt_x - iss_pkg::IDX_W'(1) - pos_x) : pos_x;
		end
	end

	// status and next count
	always_comb begin
		status_d = iss_pkg::STAT_OK;
		count_d  = count_q;
		case (req.data.cmd)
			iss_pkg::CMD_INSERT: begin
				if (ins_range_bad) begin
					status_d = iss_pkg::STAT_RANGE;
				end else if (full) begin
					status_d = iss_pkg::STAT_FULL;
				end else begin
					count_d = count_q + CNT_W'(1);
				end
			end
			iss_pkg::CMD_REMOVE: begin
				if (acc_range_bad) begin
					status_d = iss_pkg::STAT_RANGE;
				end else begin
					count_d = count_q - CNT_W'(1);
				end
			end
			iss_pkg::CMD_READ: begin
				if (acc_range_bad) begin
					status_d = iss_pkg::STAT_RANGE;
				end
			end
			default: begin
				status_d = iss_pkg::STAT_OK;
			end
		endcase
	end

	// row of cells
	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic signed [iss_pkg::DATA_W-1:0] left_w;
		logic signed [iss_pkg::DATA_W-1:0] right_w;
		if (k == 0) begin : g_head
			assign left_w = '0;
		end else begin : g_left
			assign left_w = entry[k-1];
		end
		if (k == CAPACITY - 1) begin : g_tail
			assign right_w = entry[k];
		end else begin : g_right
			assign right_w = entry[k+1];
		end
		iss_cell #(.INDEX(k)) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.value (req.data.value),
			.left  (left_w),
			.right (right_w),
			.entry (entry[k]),
			.tap   (tap[k])
		);
	end

	// read selection
	iss_or_tree #(.N(CAPACITY)) u_or_tree (
		.leaf (tap),
		.root (rd_data)
	);

	// count and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q.read_value  <= rd_data;
			out_q.status      <= status_d;
			out_q.entry_count <= iss_pkg::CNT_O_W'(count_d);
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// checks
	`ISS_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_W'(CAPACITY))
	`ISS_ASSERT(a_ctl_onehot, clk, arst_n, $onehot0({ctl.ins, ctl.rem, ctl.rd && accept}))
	`ISS_ASSERT(a_ins_grows, clk, arst_n, ctl.ins |=> count_q == $past(count_q) + CNT_W'(1))
	`ISS_ASSERT(a_full_holds, clk, arst_n, (accept && is_ins && full) |=> count_q == CNT_W'(CAPACITY))
	`ISS_ASSERT(a_tap_quiet, clk, arst_n, !ctl.rd |-> rd_data == '0)
	`ISS_ASSERT_ALWAYS(a_rst_idle, clk, !arst_n |-> !out_valid_q)

endmodule
